### design/icc_pkg.sv
// Shared types and constants for the identifier case converter.
package icc_pkg;

    localparam logic [2:0] STYLE_SNAKE    = 3'd0;
    localparam logic [2:0] STYLE_SCREAM   = 3'd1;
    localparam logic [2:0] STYLE_KEBAB    = 3'd2;
    localparam logic [2:0] STYLE_CAMEL    = 3'd3;
    localparam logic [2:0] STYLE_PASCAL   = 3'd4;

    localparam logic [7:0] SEP_UNDERSCORE = 8'h5F;
    localparam logic [7:0] SEP_DASH       = 8'h2D;
    localparam logic [7:0] CASE_OFFSET    = 8'h20;

    localparam logic       REG_STYLE_SEL  = 1'b0;

    typedef struct packed {
        logic       in_word;
        logic       prev_lower_or_digit;
        logic       word_seen;
    } word_state_t;

    typedef struct packed {
        logic [7:0] out_char;
        logic       char_valid;
        logic       text_done;
        logic       last_of_run;
    } result_t;

endpackage

### design/icc_conv.sv
// Per-byte word splitting and case conversion: up to two results per byte.
module icc_conv
    import icc_pkg::*;
(
    input  logic [7:0]  in_char,
    input  logic        last_char,
    input  logic [2:0]  style_sel,
    input  word_state_t st,
    output word_state_t st_next,
    output logic [1:0]  res_cnt,
    output result_t     res0,
    output result_t     res1
);

    logic       upper;
    logic       lower;
    logic       digit;
    logic       alnum;
    logic       starts;
    logic       later;
    logic       has_sep;
    logic       up;
    logic [7:0] low_ch;
    logic [7:0] conv_ch;
    logic [7:0] sep_ch;

    always_comb
    begin
        upper   = (in_char >= 8'h41) && (in_char <= 8'h5A);
        lower   = (in_char >= 8'h61) && (in_char <= 8'h7A);
        digit   = (in_char >= 8'h30) && (in_char <= 8'h39);
        alnum   = upper || lower || digit;
        starts  = !st.in_word || (upper && st.prev_lower_or_digit);
        later   = starts && st.word_seen;
        low_ch  = upper ? (in_char + CASE_OFFSET) : in_char;

        has_sep = later && ((style_sel == STYLE_SNAKE) || (style_sel == STYLE_SCREAM) ||
                            (style_sel == STYLE_KEBAB));
        sep_ch  = (style_sel == STYLE_KEBAB) ? SEP_DASH : SEP_UNDERSCORE;
        up      = (style_sel == STYLE_SCREAM) ||
                  ((style_sel == STYLE_PASCAL) && starts) ||
                  ((style_sel == STYLE_CAMEL) && later);
        conv_ch = (up && (upper || lower)) ? (low_ch - CASE_OFFSET) : low_ch;

        res0 = '0;
        res1 = '0;
        if (alnum && has_sep)
        begin
            res_cnt          = 2'd2;
            res0.out_char    = sep_ch;
            res0.char_valid  = 1'b1;
            res1.out_char    = conv_ch;
            res1.char_valid  = 1'b1;
            res1.text_done   = last_char;
            res1.last_of_run = 1'b1;
        end
        else if (alnum)
        begin
            res_cnt          = 2'd1;
            res0.out_char    = conv_ch;
            res0.char_valid  = 1'b1;
            res0.text_done   = last_char;
            res0.last_of_run = 1'b1;
        end
        else if (last_char)
        begin
            // bare end marker
            res_cnt          = 2'd1;
            res0.text_done   = 1'b1;
            res0.last_of_run = 1'b1;
        end
        else
        begin
            res_cnt = 2'd0;
        end

        if (last_char)
        begin
            st_next = '0;
        end
        else if (alnum)
        begin
            st_next.in_word             = 1'b1;
            st_next.word_seen           = 1'b1;
            st_next.prev_lower_or_digit = lower || digit;
        end
        else
        begin
            st_next.in_word             = 1'b0;
            st_next.prev_lower_or_digit = 1'b0;
            st_next.word_seen           = st.word_seen;
        end
    end

endmodule

### design/icc_outq.sv
// Three-entry result queue: takes up to two results a cycle, drives one out.
module icc_outq
    import icc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic [1:0] push_cnt,
    input  result_t    push0,
    input  result_t    push1,
    output logic       room,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_char
    output logic [1:0] m_tuser,   // [0] char_valid, [1] last_of_run
    output logic       m_tlast
);

    localparam int Depth = 3;

    result_t    q_reg  [Depth];
    result_t    q_next [Depth];
    result_t    src    [Depth];
    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;
    logic [1:0] cnt_ap;
    logic       pop;

    always_comb
    begin
        pop    = (cnt_reg != 2'd0) && m_tready;
        cnt_ap = cnt_reg - {1'b0, pop};
        room   = (cnt_ap <= 2'd1);

        for (int i = 0; i < Depth - 1; i++)
        begin
            src[i] = pop ? q_reg[i + 1] : q_reg[i];
        end
        src[Depth - 1] = q_reg[Depth - 1];

        for (int i = 0; i < Depth; i++)
        begin
            if (2'(i) < cnt_ap)
                q_next[i] = src[i];
            else if ((2'(i) == cnt_ap) && (push_cnt != 2'd0))
                q_next[i] = push0;
            else if ((2'(i) == cnt_ap + 2'd1) && (push_cnt == 2'd2))
                q_next[i] = push1;
            else
                q_next[i] = q_reg[i];
        end
        cnt_next = cnt_ap + push_cnt;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= 2'd0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < Depth; i++)
        begin
            q_reg[i] <= q_next[i];
        end
    end

    assign m_tvalid = (cnt_reg != 2'd0);
    assign m_tdata  = q_reg[0].out_char;
    assign m_tuser  = {q_reg[0].last_of_run, q_reg[0].char_valid};
    assign m_tlast  = q_reg[0].text_done;

endmodule

### design/identifier_case_converter.sv
// Top level of the identifier case converter.
//
// Rewrites a byte stream of identifiers into snake, screaming snake, kebab,
// camel or pascal case. Each request on the slave side is registered, then
// converted combinationally into zero, one or two results that enter a
// three-entry output queue; the master side drains one result per cycle while
// m_tready is high. A separator and a character from one byte are two results,
// bounded by the single output port. A request passes the input register and
// output queue before its first result. The user must write the style register
// at APB address 0 while the stream is idle; the block does not enforce it.
module identifier_case_converter
    import icc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_char
    input  logic        s_tlast,   // last_char
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] out_char
    output logic [1:0]  m_tuser,   // [0] char_valid, [1] last_of_run
    output logic        m_tlast,   // text_done
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [2:0]  style_sel_reg;
    logic        in_vld_reg;
    logic [7:0]  in_char_reg;
    logic        in_last_reg;
    word_state_t st_reg;
    word_state_t st_next;
    logic [1:0]  res_cnt;
    result_t     res0;
    result_t     res1;
    logic        room;
    logic        consume;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_STYLE_SEL) ? {29'd0, style_sel_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            style_sel_reg <= STYLE_SNAKE;
        else if (psel && penable && pwrite && pready && (paddr[2] == REG_STYLE_SEL))
            style_sel_reg <= pwdata[2:0];
    end

    assign consume  = in_vld_reg && room;
    assign s_tready = !in_vld_reg || consume;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
            st_reg     <= '0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                in_vld_reg <= 1'b1;
            else if (consume)
                in_vld_reg <= 1'b0;
            if (consume)
                st_reg <= st_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_char_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    icc_conv u_conv (
        .in_char    (in_char_reg),
        .last_char  (in_last_reg),
        .style_sel  (style_sel_reg),
        .st         (st_reg),
        .st_next    (st_next),
        .res_cnt    (res_cnt),
        .res0       (res0),
        .res1       (res1)
    );

    icc_outq u_outq (
        .clk      (clk),
        .rst_n    (rst_n),
        .push_cnt (consume ? res_cnt : 2'd0),
        .push0    (res0),
        .push1    (res1),
        .room     (room),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

### design/icc_checker.sv
// Port-level checks for the identifier case converter, bound to the top level.
module icc_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [7:0]  m_tdata,
    input logic [1:0]  m_tuser,
    input logic        m_tlast
);

    // stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                  && $stable(m_tlast))
        else $error("result changed while stalled");

    // a bare end marker carries no byte and closes the text
    a_marker: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] |-> m_tlast && m_tuser[1] && (m_tdata == 8'd0))
        else $error("malformed end marker");

    // end of text is always the last result of its byte
    a_done_run: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |-> m_tuser[1])
        else $error("text_done without last_of_run");

    // emitted bytes are separators, letters or digits
    a_char: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> (m_tdata == 8'h5F) || (m_tdata == 8'h2D) ||
            ((m_tdata >= 8'h30) && (m_tdata <= 8'h39)) ||
            ((m_tdata >= 8'h41) && (m_tdata <= 8'h5A)) ||
            ((m_tdata >= 8'h61) && (m_tdata <= 8'h7A)))
        else $error("unexpected output byte");

endmodule

bind identifier_case_converter icc_checker u_icc_checker (.*);
